// ----- hdl/lru_kv_pkg.sv -----
// Shared types, sizes and codes for the LRU key/value cache.
`timescale 1ns / 1ps

package lru_kv_pkg;

  // Capacity of the slot array
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int RANK_W      = IDX_W;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int WORD_W      = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Value returned by a get that misses
  localparam word_t READ_MISS = '1;

  // Capacity register reset value
  localparam cnt_t CAP_RESET = cnt_t'(MAX_ENTRIES);

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // look up, update slots and fill the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;  // result register holds an item that is not taken
  } status_t;

endpackage

// ----- hdl/lru_kv_ctrl.sv -----
// Controller: sequences item capture and the lookup/update cycle.
`timescale 1ns / 1ps

module lru_kv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lru_kv_pkg::status_t sts,
  output lru_kv_pkg::cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_stall_next;

  // Decide next state and commands
  always_comb begin
    state_next    = state;
    in_stall_next = in_stall;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next    = S_EXEC;
          in_stall_next = 1'b1;
        end
      end
      S_EXEC: begin
        cmd.exec = !sts.out_busy;
        if (!sts.out_busy) begin
          state_next    = S_IDLE;
          in_stall_next = 1'b0;
        end
      end
      default: begin
        state_next    = S_IDLE;
        in_stall_next = 1'b0;
      end
    endcase
  end

  // Hold state and the registered stall
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= in_stall_next;
    end
  end

endmodule

// ----- hdl/lru_kv_dp.sv -----
// Datapath: slot array, parallel key compare, age-rank update and result register.
`timescale 1ns / 1ps

module lru_kv_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  lru_kv_pkg::cmd_t           cmd,
  output lru_kv_pkg::status_t        sts,
  input  logic                       operation,
  input  logic signed [31:0]         key,
  input  logic signed [31:0]         value,
  input  logic                       cfg_valid,
  input  logic [lru_kv_pkg::CNT_W-1:0] cfg_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       hit,
  output logic signed [31:0]         read_value,
  output logic                       evicted,
  output logic signed [31:0]         evicted_key
);

  // Captured item
  logic              req_op;
  lru_kv_pkg::word_t req_key;
  lru_kv_pkg::word_t req_value;

  // Slot storage
  logic              slot_valid [lru_kv_pkg::MAX_ENTRIES];
  lru_kv_pkg::word_t slot_key   [lru_kv_pkg::MAX_ENTRIES];
  lru_kv_pkg::word_t slot_value [lru_kv_pkg::MAX_ENTRIES];
  lru_kv_pkg::rank_t slot_rank  [lru_kv_pkg::MAX_ENTRIES];
  lru_kv_pkg::cnt_t  used_count;
  lru_kv_pkg::cnt_t  cap_in_use;

  // Lookup results
  logic              found;
  lru_kv_pkg::idx_t  found_idx;
  lru_kv_pkg::idx_t  lru_idx;
  lru_kv_pkg::idx_t  free_idx;
  lru_kv_pkg::idx_t  dst_idx;
  lru_kv_pkg::rank_t touch_rank;
  lru_kv_pkg::rank_t oldest_rank;
  lru_kv_pkg::cnt_t  eff_cap;
  logic              do_insert;
  logic              do_evict;
  logic              out_take;

  assign out_take     = out_valid && !out_stall;
  assign sts.out_busy = out_valid && out_stall;

  // Clamp the capacity register to 1..MAX_ENTRIES
  always_comb begin
    eff_cap = cap_in_use;
    if (cap_in_use == '0) begin
      eff_cap = lru_kv_pkg::cnt_t'(1);
    end else if (cap_in_use > lru_kv_pkg::cnt_t'(lru_kv_pkg::MAX_ENTRIES)) begin
      eff_cap = lru_kv_pkg::cnt_t'(lru_kv_pkg::MAX_ENTRIES);
    end
  end

  // Ranks of valid slots run 0..used_count-1, so the oldest has rank used_count-1
  assign oldest_rank = lru_kv_pkg::rank_t'(used_count - lru_kv_pkg::cnt_t'(1));

  // Compare all slots in parallel; lowest index wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    lru_idx   = '0;
    free_idx  = '0;
    for (int i = lru_kv_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == req_key) begin
        found     = 1'b1;
        found_idx = lru_kv_pkg::idx_t'(i);
      end
      if (slot_valid[i] && slot_rank[i] == oldest_rank) begin
        lru_idx = lru_kv_pkg::idx_t'(i);
      end
      if (!slot_valid[i]) begin
        free_idx = lru_kv_pkg::idx_t'(i);
      end
    end
  end

  assign touch_rank = slot_rank[found_idx];
  assign do_insert  = (req_op == lru_kv_pkg::OP_PUT) && !found;
  assign do_evict   = do_insert && (used_count >= eff_cap) && (used_count != '0);
  assign dst_idx    = do_evict ? lru_kv_pkg::idx_t'(lru_idx) : free_idx;

  // Capacity register, used count, slot valid marks and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_in_use <= lru_kv_pkg::CAP_RESET;
      used_count <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < lru_kv_pkg::MAX_ENTRIES; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else begin
      if (cfg_valid) begin
        cap_in_use <= cfg_data;
      end
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      if (cmd.exec && do_insert) begin
        slot_valid[dst_idx] <= 1'b1;
        if (!do_evict) begin
          used_count <= used_count + lru_kv_pkg::cnt_t'(1);
        end
      end
    end
  end

  // Payload registers: item, slot contents, ranks and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= operation;
      req_key   <= key;
      req_value <= value;
    end
    if (cmd.exec) begin
      if (found) begin
        // Touch: younger valid slots age by one, the hit slot becomes newest
        for (int i = 0; i < lru_kv_pkg::MAX_ENTRIES; i++) begin
          if (slot_valid[i] && lru_kv_pkg::idx_t'(i) != found_idx &&
              slot_rank[i] < touch_rank) begin
            slot_rank[i] <= slot_rank[i] + lru_kv_pkg::rank_t'(1);
          end
        end
        slot_rank[found_idx] <= '0;
        if (req_op == lru_kv_pkg::OP_PUT) begin
          slot_value[found_idx] <= req_value;
        end
      end else if (do_insert) begin
        // Insert: every other valid slot ages by one
        for (int i = 0; i < lru_kv_pkg::MAX_ENTRIES; i++) begin
          if (slot_valid[i] && lru_kv_pkg::idx_t'(i) != dst_idx) begin
            slot_rank[i] <= slot_rank[i] + lru_kv_pkg::rank_t'(1);
          end
        end
        slot_rank[dst_idx]  <= '0;
        slot_key[dst_idx]   <= req_key;
        slot_value[dst_idx] <= req_value;
      end

      // Fill the result register
      hit         <= found;
      evicted     <= do_evict;
      evicted_key <= do_evict ? slot_key[lru_idx] : '0;
      if (req_op == lru_kv_pkg::OP_GET) begin
        read_value <= found ? slot_value[found_idx] : lru_kv_pkg::READ_MISS;
      end else begin
        read_value <= '0;
      end
    end
  end

endmodule

// ----- hdl/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key/value cache.
// The accepting edge captures the item; the result register is filled by the single
// compare-and-update cycle over all slots, once the previous result is taken. A new
// item waits for that cycle; a stalled result holds the update cycle of the next item.
// Reset: clears all valid marks and the used count, sets the capacity to 16;
// key, value and rank storage is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module lru_key_value_cache (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic signed [31:0]           key,
  input  logic signed [31:0]           value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lru_kv_pkg::CNT_W-1:0] cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic signed [31:0]           read_value,
  output logic                         evicted,
  output logic signed [31:0]           evicted_key
);

  lru_kv_pkg::cmd_t    cmd;
  lru_kv_pkg::status_t sts;
  logic                cfg_write;

  // The user must write the capacity only while idle; the block itself does not enforce this
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  lru_kv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lru_kv_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .operation   (operation),
    .key         (key),
    .value       (value),
    .cfg_valid   (cfg_write),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

  // An accepted item blocks the input until its update cycle runs
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after item accept");

  // A new result appears only from the update cycle of a held item
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a captured item");

  // An eviction only happens on a miss
  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> !hit)
    else $error("eviction reported on a hit");

  // Evicted key is zero when nothing was removed
  a_evict_key_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted) |-> (evicted_key == '0))
    else $error("evicted key set without eviction");

endmodule
